>>> hdl/sdms_pkg.sv
package sdms_pkg;

  // window depths (powers of two keep the scale factors exact)
  localparam int ULTRA_DEPTH = 32;
  localparam int IR_DEPTH    = 8;

  localparam int SAMPLE_W = 10;
  localparam int TOP_W    = 8;
  localparam int LEVEL_W  = 16;
  localparam int MODE_W   = 2;

  localparam int MAX_DEPTH = (ULTRA_DEPTH > IR_DEPTH) ? ULTRA_DEPTH : IR_DEPTH;
  localparam int SLOT_W    = $clog2(MAX_DEPTH);
  // one shared store: upper half phase high, lower half phase low
  localparam int RAM_AW    = SLOT_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;
  localparam int RAM_W     = SAMPLE_W;

  localparam int IR_SUM_W  = SAMPLE_W + $clog2(IR_DEPTH);
  localparam int US_DIFF_W = TOP_W + 1 + $clog2(ULTRA_DEPTH);

  localparam int IR_SAT    = 750 * IR_DEPTH;
  localparam int IR_CLIP   = 1023 * IR_DEPTH;
  localparam int IR_SCALE  = 64 / IR_DEPTH;
  localparam int US_SCALE  = 256 / ULTRA_DEPTH;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LEVEL_W-1:0]  level_t;

  localparam mode_t MODE_OFF = 2'd0;
  localparam mode_t MODE_IR  = 2'd1;
  localparam mode_t MODE_US  = 2'd2;

  localparam logic REG_MODE = 1'b0;

  typedef struct packed {
    mode_t mode;
    logic  clear;
  } sdms_ctl_t;

  typedef struct packed {
    logic busy;
  } sdms_stat_t;

endpackage

>>> hdl/sdms_in_if.sv
interface sdms_in_if import sdms_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    phase;

  modport source (output valid, output sample, output phase, input ready);
  modport sink (input valid, input sample, input phase, output ready);
endinterface

>>> hdl/sdms_out_if.sv
interface sdms_out_if import sdms_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

>>> hdl/sdms_ram.sv
module sdms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sdms_cfg.sv
module sdms_cfg import sdms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output sdms_ctl_t         ctl
);

  mode_t mode_r, mode_nxt;
  logic  wr_hit;

  // register index is the word address
  assign wr_hit = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_MODE);

  always_comb begin
    mode_nxt = mode_r;
    if (wr_hit) begin
      mode_nxt = pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OFF;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign prdata    = (paddr[CFG_AW-1] == REG_MODE) ? CFG_DW'(mode_r) : '0;
  assign pready    = 1'b1;
  assign ctl.mode  = mode_r;
  assign ctl.clear = wr_hit;

endmodule

>>> hdl/sdms_core.sv
module sdms_core import sdms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sdms_ctl_t  ctl,
  sdms_in_if.sink    in_if,
  sdms_out_if.source out_if,
  output sdms_stat_t stat
);

  logic [1:0][SLOT_W-1:0] slot_r, slot_nxt;
  logic [RAM_DEPTH-1:0]   vld_r, vld_nxt;
  logic                   s1_v_r, s1_v_nxt;
  logic [RAM_AW-1:0]      s1_idx_r;
  sample_t                s1_smp_r;
  logic                   s1_ph_r;
  logic [IR_SUM_W-1:0]    lit_r, lit_nxt, dark_r, dark_nxt;
  logic [US_DIFF_W-1:0]   pd_r, pd_nxt;
  logic                   out_v_r, out_v_nxt;
  level_t                 level_r, level_nxt;

  logic                   active, adv, accept, fire, wr_en;
  logic [SLOT_W-1:0]      cur_slot;
  logic [SLOT_W:0]        slot_inc, depth;
  logic [RAM_W-1:0]       rdata, old, wdata;
  logic [TOP_W-1:0]       top;
  logic [IR_SUM_W-1:0]    ir_res;
  logic [31:0]            ir_prod, us_prod;

  assign active = (ctl.mode == MODE_IR) || (ctl.mode == MODE_US);
  assign adv    = !out_v_r || out_if.ready;
  assign in_if.ready = !s1_v_r || adv;
  assign accept = in_if.valid && in_if.ready;
  assign fire   = s1_v_r && adv;
  assign wr_en  = fire && active;

  // slot bookkeeping at accept
  assign cur_slot = slot_r[in_if.phase];
  assign slot_inc = (SLOT_W+1)'(cur_slot) + (SLOT_W+1)'(1);
  assign depth    = (ctl.mode == MODE_IR) ? (SLOT_W+1)'(IR_DEPTH) : (SLOT_W+1)'(ULTRA_DEPTH);

  always_comb begin
    slot_nxt = slot_r;
    if (accept && active) begin
      slot_nxt[in_if.phase] = (slot_inc >= depth) ? '0 : slot_inc[SLOT_W-1:0];
    end
  end

  sdms_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RAM_DEPTH)
  ) u_win (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx_r),
    .wdata (wdata),
    .re    (accept),
    .raddr ({in_if.phase, cur_slot}),
    .rdata (rdata)
  );

  // never-written entries read as zero
  assign old = vld_r[s1_idx_r] ? rdata : '0;
  assign top = s1_smp_r[SAMPLE_W-1:SAMPLE_W-TOP_W];

  always_comb begin
    lit_nxt  = lit_r;
    dark_nxt = dark_r;
    pd_nxt   = pd_r;
    wdata    = s1_smp_r;
    if (ctl.mode == MODE_IR) begin
      if (!s1_ph_r) begin
        lit_nxt = lit_r - IR_SUM_W'(old) + IR_SUM_W'(s1_smp_r);
      end else begin
        dark_nxt = dark_r - IR_SUM_W'(old) + IR_SUM_W'(s1_smp_r);
      end
    end else begin
      wdata = RAM_W'(top);
      if (s1_ph_r) begin
        pd_nxt = pd_r + US_DIFF_W'(top) - US_DIFF_W'(old[TOP_W-1:0]);
      end else begin
        pd_nxt = pd_r + US_DIFF_W'(old[TOP_W-1:0]) - US_DIFF_W'(top);
      end
    end
  end

  always_comb begin
    priority if (lit_nxt < dark_nxt) begin
      ir_res = '0;
    end else if (lit_nxt > IR_SUM_W'(IR_SAT)) begin
      ir_res = IR_SUM_W'(IR_CLIP);
    end else begin
      ir_res = lit_nxt - dark_nxt;
    end
  end

  assign ir_prod = 32'(ir_res) * 32'(IR_SCALE);
  assign us_prod = 32'(pd_nxt[US_DIFF_W-2:0]) * 32'(US_SCALE);

  always_comb begin
    unique case (ctl.mode)
      MODE_IR: level_nxt = ir_prod[LEVEL_W-1:0];
      MODE_US: level_nxt = pd_nxt[US_DIFF_W-1] ? '0 : us_prod[LEVEL_W-1:0];
      default: level_nxt = '0;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[s1_idx_r] = 1'b1;
    end
  end

  assign s1_v_nxt  = accept ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = fire ? 1'b1 : (out_if.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      slot_r  <= '0;
      vld_r   <= '0;
      lit_r   <= '0;
      dark_r  <= '0;
      pd_r    <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (ctl.clear) begin
        slot_r <= '0;
        vld_r  <= '0;
        lit_r  <= '0;
        dark_r <= '0;
        pd_r   <= '0;
      end else begin
        slot_r <= slot_nxt;
        vld_r  <= vld_nxt;
        if (wr_en) begin
          lit_r  <= lit_nxt;
          dark_r <= dark_nxt;
          pd_r   <= pd_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r <= {in_if.phase, cur_slot};
      s1_smp_r <= in_if.sample;
      s1_ph_r  <= in_if.phase;
    end
    if (fire) begin
      level_r <= level_nxt;
    end
  end

  assign out_if.valid = out_v_r;
  assign out_if.level = level_r;
  assign stat.busy    = s1_v_r || out_v_r;

endmodule

>>> hdl/synchronous_demod_moving_sum.sv
// Lock-in detector with moving-sum windows. Every input transaction (10-bit
// sample plus emitter phase) yields exactly one output transaction carrying a
// 16-bit level. Throughput is one transaction per clock while out_if.ready
// is high. The window store read is launched at the accepting edge
// (registered-read RAM). The second stage then does the read-modify-write of
// the running sum, and the level derived from it lands in the output
// register, which drives out_if.valid. A stalled output register holds the
// second stage, and only then does in_if.ready drop. Mode (register 0, byte
// address 0): 0 off (level 0, state untouched), 1 infrared lit/dark windows,
// 2 ultrasonic phase windows; 3 acts as off. Any write to mode empties all
// windows and sums at once through per-entry valid bits, so there is no
// clearing pass. Write mode only while no transaction is in flight.
module synchronous_demod_moving_sum import sdms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sdms_in_if.sink           in_if,
  sdms_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  sdms_ctl_t  ctl;
  sdms_stat_t stat;

  // mode register, clear pulse on every mode write
  sdms_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  // window store, running sums, output register
  sdms_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .in_if  (in_if),
    .out_if (out_if),
    .stat   (stat)
  );

  // input backpressure only comes from a full output register
  a_ready_needs_full_out : assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled with empty output register");

  // an accepted transaction is always in flight next cycle
  a_accept_tracked : assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> stat.busy)
    else $error("accepted transaction lost");

  // nothing is presented unless the pipeline holds it
  a_out_from_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> !out_if.valid)
    else $error("output valid with empty pipeline");

endmodule

>>> tb/tb_synchronous_demod_moving_sum.sv
`timescale 1ns / 1ps

// Self-checking bench for the lock-in detector.
// A scoreboard model of the IR/ultrasonic windows predicts one level per
// accepted sample; the monitor compares every output transaction in order.
module tb_synchronous_demod_moving_sum;
  import sdms_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  // idle tail after the last result, before the next mode write
  localparam int TAIL_CYCLES    = 8;
  // one long back-pressure episode on the output side
  localparam int LONG_HOLD      = 200;
  localparam int HOLD_AFTER     = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  // unused mode code, decodes as off
  localparam mode_t MODE_SPARE = 2'd3;
  localparam logic [CFG_AW-1:0] MODE_ADDR = CFG_AW'(REG_MODE) << 2;

  typedef struct packed {
    sample_t sample;
    logic    phase;
  } reading_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  sdms_in_if  in_ch();
  sdms_out_if out_ch();

  synchronous_demod_moving_sum dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // Scoreboard model state: a private copy of mode and of all windows.
  // ---------------------------------------------------------------------
  mode_t cur_mode = MODE_OFF;

  // IR: emitter lit (phase low) and dark (phase high) windows
  logic [SAMPLE_W-1:0] lit_win  [IR_DEPTH];
  logic [SAMPLE_W-1:0] dark_win [IR_DEPTH];
  int unsigned         lit_idx, dark_idx;
  logic [IR_SUM_W-1:0] lit_sum, dark_sum;

  // ultrasonic: top 8 sample bits, phase high and phase low windows
  logic [TOP_W-1:0]            hi_win [ULTRA_DEPTH];
  logic [TOP_W-1:0]            lo_win [ULTRA_DEPTH];
  int unsigned                 hi_idx, lo_idx;
  logic signed [US_DIFF_W-1:0] hi_lo_diff;

  reading_t reading_q[$];        // samples waiting for the driver
  level_t   level_expect_q[$];   // predicted levels, oldest first

  int queued_total   = 0;
  int accepted_total = 0;
  int results_seen   = 0;
  int fail_count     = 0;

  // any mode write empties everything
  function automatic void clear_windows();
    foreach (lit_win[i]) begin
      lit_win[i]  = '0;
      dark_win[i] = '0;
    end
    foreach (hi_win[i]) begin
      hi_win[i] = '0;
      lo_win[i] = '0;
    end
    lit_idx    = 0;
    dark_idx   = 0;
    lit_sum    = '0;
    dark_sum   = '0;
    hi_idx     = 0;
    lo_idx     = 0;
    hi_lo_diff = '0;
  endfunction

  // Takes one sample into the windows and returns the demodulated level.
  function automatic level_t demod_predict(sample_t s, logic ph);
    logic [TOP_W-1:0]    top;
    logic [IR_SUM_W-1:0] ir_val;
    top = s[SAMPLE_W-1 -: TOP_W];
    case (cur_mode)
      MODE_IR: begin
        if (!ph) begin
          lit_sum           = lit_sum - lit_win[lit_idx] + s;
          lit_win[lit_idx]  = s;
          lit_idx           = (lit_idx + 1) % IR_DEPTH;
        end else begin
          dark_sum          = dark_sum - dark_win[dark_idx] + s;
          dark_win[dark_idx] = s;
          dark_idx          = (dark_idx + 1) % IR_DEPTH;
        end
        // dark brighter than lit: nothing reflected
        if (lit_sum < dark_sum)
          ir_val = '0;
        // detector saturated: report full scale
        else if (lit_sum > IR_SAT)
          ir_val = IR_SUM_W'(IR_CLIP);
        else
          ir_val = lit_sum - dark_sum;
        return level_t'(ir_val * IR_SCALE);
      end
      MODE_US: begin
        if (ph) begin
          hi_lo_diff = hi_lo_diff - $signed({1'b0, hi_win[hi_idx]}) + $signed({1'b0, top});
          hi_win[hi_idx] = top;
          hi_idx = (hi_idx + 1) % ULTRA_DEPTH;
        end else begin
          hi_lo_diff = hi_lo_diff + $signed({1'b0, lo_win[lo_idx]}) - $signed({1'b0, top});
          lo_win[lo_idx] = top;
          lo_idx = (lo_idx + 1) % ULTRA_DEPTH;
        end
        // negative difference clamps to zero
        if (hi_lo_diff < 0)
          return '0;
        return level_t'(int'(hi_lo_diff) * US_SCALE);
      end
      default: begin
        // off and the spare code: level 0, windows untouched
        return '0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of random length with random gaps. Valid is held until
  // the transaction is taken; prediction happens at the accepting edge.
  // ---------------------------------------------------------------------
  int       send_burst_left = 0;
  int       send_gap_left   = 0;
  reading_t next_reading;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= '0;
      in_ch.phase  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        level_expect_q.push_back(demod_predict(in_ch.sample, in_ch.phase));
        accepted_total++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // stalled: keep offering the same transaction
      end else if (send_gap_left > 0) begin
        send_gap_left--;
        in_ch.valid <= 1'b0;
      end else if (reading_q.size() > 0) begin
        next_reading = reading_q.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.sample <= next_reading.sample;
        in_ch.phase  <= next_reading.phase;
        if (send_burst_left == 0)
          send_burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 24);
        send_burst_left--;
        // a third of the bursts run straight into the next one
        if (send_burst_left == 0)
          send_gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each output transaction against the oldest prediction
  // and drives ready from a pattern that is picked anew at random intervals.
  // ---------------------------------------------------------------------
  int     hold_left      = 0;
  logic   long_hold_done = 1'b0;
  int     pattern_kind   = 0;
  int     pattern_left   = 0;
  level_t want_level;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (level_expect_q.size() == 0) begin
          $error("level: no transaction expected, got %0d", out_ch.level);
          fail_count++;
        end else begin
          want_level = level_expect_q.pop_front();
          if (out_ch.level !== want_level) begin
            $error("level: expected %0d, got %0d", want_level, out_ch.level);
            fail_count++;
          end
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        // long hold-off: pipeline fills and in_ch.ready must drop
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        out_ch.ready  <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_kind = $urandom_range(0, 3);
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        case (pattern_kind)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= (pattern_left % 3 == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic queue_item(sample_t s, logic ph);
    reading_q.push_back('{sample: s, phase: ph});
    queued_total++;
  endtask

  // lit samples lean high (and around the saturation knee), dark ones low
  function automatic sample_t pick_sample(logic ph);
    case ($urandom_range(0, 3))
      0:       return sample_t'($urandom_range(0, 1023));
      1:       return ph ? sample_t'($urandom_range(0, 300)) : sample_t'($urandom_range(735, 765));
      2:       return sample_t'($urandom_range(1000, 1023));
      default: return ph ? sample_t'($urandom_range(0, 40)) : sample_t'($urandom_range(600, 1023));
    endcase
  endfunction

  // Mostly an emitter square wave, with occasional long single-phase runs
  // to push the ultrasonic difference to its extremes, plus some noise.
  task automatic add_random_items(int count);
    logic run_phase;
    int   run_left;
    run_phase = 1'b0;
    run_left  = 0;
    repeat (count) begin
      if ($urandom_range(0, 6) == 0) begin
        queue_item(sample_t'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      end else begin
        if (run_left == 0) begin
          run_phase = ~run_phase;
          run_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 40) : 1;
        end
        run_left--;
        queue_item(pick_sample(run_phase), run_phase);
      end
    end
  endtask

  // sender stops until every queued sample is taken and every level is back
  task automatic wait_drained();
    while (accepted_total != queued_total || level_expect_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // APB write of the mode register, then read it back
  task automatic write_mode(mode_t m);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= CFG_DW'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = m;
    clear_windows();

    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(m)) begin
      $error("mode: expected %0d, got %0d", m, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    clear_windows();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // off straight out of reset
    queue_item(10'd0, 1'b0);
    queue_item(10'd1023, 1'b1);
    add_random_items(20);
    wait_drained();

    // IR: a dark zero, lit climbing into saturation, dark rising, a lit zero,
    // then a lit sample at the per-sample saturation value
    write_mode(MODE_IR);
    queue_item(10'd0, 1'b1);
    repeat (6) queue_item(10'd1023, 1'b0);
    repeat (2) queue_item(10'd1023, 1'b1);
    queue_item(10'd0, 1'b0);
    queue_item(10'd750, 1'b0);
    add_random_items(350);
    wait_drained();

    // rewriting the same mode must still empty the windows
    write_mode(MODE_IR);
    add_random_items(150);
    wait_drained();

    // ultrasonic: full-scale high, low bits dropped, negative difference
    write_mode(MODE_US);
    queue_item(10'd1023, 1'b1);
    queue_item(10'd3, 1'b1);
    queue_item(10'd4, 1'b0);
    queue_item(10'd1020, 1'b0);
    queue_item(10'd512, 1'b0);
    add_random_items(400);
    wait_drained();

    // spare code acts as off
    write_mode(MODE_SPARE);
    queue_item(10'd1023, 1'b0);
    queue_item(10'd1023, 1'b1);
    add_random_items(40);
    wait_drained();

    write_mode(MODE_OFF);
    add_random_items(30);
    wait_drained();

    write_mode(MODE_US);
    add_random_items(150);
    wait_drained();

    write_mode(MODE_IR);
    add_random_items(150);
    wait_drained();

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
